FILE: rtl/ifa_pkg.sv
package ifa_pkg;

    localparam int SUM_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int DUTY_W     = 16;
    localparam int GAIN_W     = 2;
    localparam int SW_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTORANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_THRESH_HI  = 16'd20000;
    localparam logic [CFG_DATA_W-1:0] RST_THRESH_LO  = 16'd1800;
    localparam logic [CFG_DATA_W-1:0] RST_FULL_SCALE = 16'd17500;

    // gain steps and switch codes
    localparam logic [GAIN_W-1:0] GAIN_LOW  = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_MID  = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_HIGH = 2'd2;
    localparam logic [SW_W-1:0]   SW_KEEP   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_LOAD
    } ifa_state_t;

    typedef struct packed {
        logic take_item;
        logic prep;
        logic div_step;
        logic load_out;
    } ifa_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic out_free;
    } ifa_status_t;

endpackage

FILE: rtl/ifa_ctrl.sv
module ifa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ifa_pkg::ifa_status_t status,
    output ifa_pkg::ifa_cmd_t    cmd
);

    ifa_pkg::ifa_state_t state_reg;
    ifa_pkg::ifa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ifa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ifa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    if (status.frame_end) begin
                        state_next = ifa_pkg::ST_PREP;
                    end
                end
            end
            ifa_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ifa_pkg::ST_DIV;
            end
            ifa_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ifa_pkg::ST_LOAD;
                end
            end
            ifa_pkg::ST_LOAD: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ifa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ifa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ifa_datapath.sv
module ifa_datapath #(
    parameter int PAIRS_PER_FRAME = 15,
    parameter int ADC_BITS        = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [ADC_BITS-1:0]                   s_adc_reading,
    input  logic [ifa_pkg::SW_W-1:0]              s_switch_code,
    input  logic                                  cfg_valid,
    input  logic [ifa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ifa_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  ifa_pkg::ifa_cmd_t                     cmd,
    output ifa_pkg::ifa_status_t                  status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ifa_pkg::SUM_W-1:0]             m_baseline_sum,
    output logic [ifa_pkg::SUM_W-1:0]             m_value_sum,
    output logic signed [ifa_pkg::DIFF_W-1:0]     m_difference_sum,
    output logic [ifa_pkg::GAIN_W-1:0]            m_frame_gain,
    output logic [ifa_pkg::GAIN_W-1:0]            m_next_gain,
    output logic [ifa_pkg::DUTY_W-1:0]            m_pwm_duty
);

    localparam int CNT_W = (PAIRS_PER_FRAME > 1) ? $clog2(PAIRS_PER_FRAME) : 1;
    localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(PAIRS_PER_FRAME - 1);
    localparam int SUM_W  = ifa_pkg::SUM_W;
    localparam int DIFF_W = ifa_pkg::DIFF_W;
    localparam int DUTY_W = ifa_pkg::DUTY_W;

    // configuration
    logic                          autorange_reg;
    logic [ifa_pkg::CFG_DATA_W-1:0] thresh_hi_reg;
    logic [ifa_pkg::CFG_DATA_W-1:0] thresh_lo_reg;
    logic [ifa_pkg::CFG_DATA_W-1:0] full_scale_reg;

    // frame state
    logic                          expect_base_reg;
    logic [ADC_BITS-1:0]           held_base_reg;
    logic [SUM_W-1:0]              base_acc_reg;
    logic [SUM_W-1:0]              value_acc_reg;
    logic [DIFF_W-1:0]             diff_acc_reg;
    logic [CNT_W-1:0]              pair_cnt_reg;
    logic [ifa_pkg::GAIN_W-1:0]    gain_reg;
    logic [ifa_pkg::SW_W-1:0]      sw_reg;
    logic [ifa_pkg::GAIN_W-1:0]    next_gain_reg;

    // divider
    logic [DUTY_W-1:0]             rem_reg;
    logic [DUTY_W-1:0]             quot_reg;
    logic [ifa_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic                          m_valid_reg;

    logic [DUTY_W-1:0]             fs_eff;
    logic signed [DIFF_W:0]        diff_ext;
    logic [DUTY_W-1:0]             clamp_c;
    logic [2*DUTY_W-1:0]           numer;
    logic [ifa_pkg::GAIN_W-1:0]    gain_next;
    logic [DUTY_W:0]               trial;
    logic                          trial_ge;

    assign fs_eff   = (full_scale_reg == '0) ? DUTY_W'(1) : full_scale_reg;
    assign diff_ext = $signed({diff_acc_reg[DIFF_W-1], diff_acc_reg});

    always_comb begin
        if (diff_acc_reg[DIFF_W-1] || diff_acc_reg == '0) begin
            clamp_c = '0;
        end else if (diff_acc_reg[DUTY_W-1:0] >= fs_eff) begin
            clamp_c = fs_eff;
        end else begin
            clamp_c = diff_acc_reg[DUTY_W-1:0];
        end
        // c * 65535 + fs / 2, built without a multiplier
        numer = {clamp_c, {DUTY_W{1'b0}}} - (2*DUTY_W)'(clamp_c)
              + (2*DUTY_W)'(fs_eff >> 1);
    end

    always_comb begin
        gain_next = gain_reg;
        if (autorange_reg) begin
            if (diff_ext > $signed({2'b00, thresh_hi_reg})) begin
                gain_next = (gain_reg == ifa_pkg::GAIN_HIGH) ? ifa_pkg::GAIN_MID
                                                             : ifa_pkg::GAIN_LOW;
            end else if (diff_ext < $signed({2'b00, thresh_lo_reg})) begin
                gain_next = (gain_reg == ifa_pkg::GAIN_LOW) ? ifa_pkg::GAIN_MID
                                                            : ifa_pkg::GAIN_HIGH;
            end
        end else if (sw_reg != ifa_pkg::SW_KEEP) begin
            gain_next = sw_reg;
        end
    end

    // one restoring step: quotient bits shift in at the bottom of quot_reg
    assign trial    = {rem_reg, quot_reg[DUTY_W-1]};
    assign trial_ge = trial >= {1'b0, fs_eff};

    assign status.frame_end = !expect_base_reg && (pair_cnt_reg == LAST_PAIR);
    assign status.div_last  = div_cnt_reg == ifa_pkg::DIV_CNT_W'(ifa_pkg::DIV_STEPS - 1);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            autorange_reg  <= 1'b1;
            thresh_hi_reg  <= ifa_pkg::RST_THRESH_HI;
            thresh_lo_reg  <= ifa_pkg::RST_THRESH_LO;
            full_scale_reg <= ifa_pkg::RST_FULL_SCALE;
        end else if (cfg_valid) begin
            case (cfg_index)
                ifa_pkg::REG_AUTORANGE:  autorange_reg  <= cfg_data[0];
                ifa_pkg::REG_THRESH_HI:  thresh_hi_reg  <= cfg_data;
                ifa_pkg::REG_THRESH_LO:  thresh_lo_reg  <= cfg_data;
                ifa_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_base_reg <= 1'b1;
            held_base_reg   <= '0;
            base_acc_reg    <= '0;
            value_acc_reg   <= '0;
            diff_acc_reg    <= '0;
            pair_cnt_reg    <= '0;
            gain_reg        <= ifa_pkg::GAIN_MID;
        end else if (cmd.take_item) begin
            if (expect_base_reg) begin
                held_base_reg   <= s_adc_reading;
                expect_base_reg <= 1'b0;
            end else begin
                expect_base_reg <= 1'b1;
                base_acc_reg    <= base_acc_reg + SUM_W'(held_base_reg);
                value_acc_reg   <= value_acc_reg + SUM_W'(s_adc_reading);
                diff_acc_reg    <= diff_acc_reg + DIFF_W'(s_adc_reading)
                                 - DIFF_W'(held_base_reg);
                pair_cnt_reg    <= status.frame_end ? '0 : pair_cnt_reg + 1'b1;
            end
        end else if (cmd.load_out) begin
            base_acc_reg  <= '0;
            value_acc_reg <= '0;
            diff_acc_reg  <= '0;
            gain_reg      <= next_gain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            sw_reg <= s_switch_code;
        end
        if (cmd.prep) begin
            next_gain_reg <= gain_next;
            rem_reg       <= numer[2*DUTY_W-1:DUTY_W];
            quot_reg      <= numer[DUTY_W-1:0];
            div_cnt_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= trial_ge ? DUTY_W'(trial - {1'b0, fs_eff}) : trial[DUTY_W-1:0];
            quot_reg    <= {quot_reg[DUTY_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_baseline_sum   <= base_acc_reg;
            m_value_sum      <= value_acc_reg;
            m_difference_sum <= $signed(diff_acc_reg);
            m_frame_gain     <= gain_reg;
            m_next_gain      <= next_gain_reg;
            m_pwm_duty       <= quot_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/integrator_frame_autorange_unit.sv
// Integrator frame accumulator with automatic gain ranging.
// Input channel (s_valid/s_ready): one ADC reading per item, baseline and
// post-sync value alternating, the first item after reset being a baseline.
// s_switch_code is taken from the item that closes a frame when autoranging
// is off. Result channel (m_valid/m_ready): one item per frame of
// PAIRS_PER_FRAME pairs, carrying the three frame sums, the gain used, the
// gain chosen for the next frame and the PWM duty.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; write only while no frame is being closed.
// s_ready stays high after an item that does not close a frame. The
// frame-closing item passes these steps in order before its result is shown:
// accumulate, clamp and form the dividend, the bit-serial duty divider, and
// load the output register; s_ready is low from the clamp step to the load.
// If the receiver stalls, the result holds in the output register and input
// items are still taken until the next frame closes; that frame then waits
// in the load step. Reset (aresetn, synchronous, active low) restores the
// register defaults, mid gain, empty sums and expects a baseline next.
module integrator_frame_autorange_unit #(
    parameter int PAIRS_PER_FRAME = 15,
    parameter int ADC_BITS        = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ADC_BITS-1:0]               s_adc_reading,
    input  logic [ifa_pkg::SW_W-1:0]          s_switch_code,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ifa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ifa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ifa_pkg::SUM_W-1:0]         m_baseline_sum,
    output logic [ifa_pkg::SUM_W-1:0]         m_value_sum,
    output logic signed [ifa_pkg::DIFF_W-1:0] m_difference_sum,
    output logic [ifa_pkg::GAIN_W-1:0]        m_frame_gain,
    output logic [ifa_pkg::GAIN_W-1:0]        m_next_gain,
    output logic [ifa_pkg::DUTY_W-1:0]        m_pwm_duty
);

    ifa_pkg::ifa_cmd_t    cmd;
    ifa_pkg::ifa_status_t status;

    assign cfg_ready = 1'b1;

    ifa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ifa_datapath #(
        .PAIRS_PER_FRAME (PAIRS_PER_FRAME),
        .ADC_BITS        (ADC_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_adc_reading    (s_adc_reading),
        .s_switch_code    (s_switch_code),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_baseline_sum   (m_baseline_sum),
        .m_value_sum      (m_value_sum),
        .m_difference_sum (m_difference_sum),
        .m_frame_gain     (m_frame_gain),
        .m_next_gain      (m_next_gain),
        .m_pwm_duty       (m_pwm_duty)
    );

endmodule

FILE: rtl/ifa_checker.sv
module ifa_checker #(
    parameter int PAIRS_PER_FRAME = 15,
    parameter int ADC_BITS        = 12
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [ADC_BITS-1:0]               s_adc_reading,
    input logic [ifa_pkg::SW_W-1:0]          s_switch_code,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [ifa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [ifa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ifa_pkg::SUM_W-1:0]         m_baseline_sum,
    input logic [ifa_pkg::SUM_W-1:0]         m_value_sum,
    input logic signed [ifa_pkg::DIFF_W-1:0] m_difference_sum,
    input logic [ifa_pkg::GAIN_W-1:0]        m_frame_gain,
    input logic [ifa_pkg::GAIN_W-1:0]        m_next_gain,
    input logic [ifa_pkg::DUTY_W-1:0]        m_pwm_duty
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pwm_duty)
            && $stable(m_difference_sum) && $stable(m_next_gain))
        else $error("stalled result changed");

    // a result needs the whole divide: an item taken never shows one in the next cycle
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result shown straight after an item");

    a_gain_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_gain != ifa_pkg::SW_KEEP && m_next_gain != ifa_pkg::SW_KEEP)
        else $error("illegal gain step");

    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_difference_sum[ifa_pkg::DIFF_W-1] || m_difference_sum == '0)
            |-> m_pwm_duty == '0)
        else $error("non-positive sum gave a duty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind integrator_frame_autorange_unit ifa_checker #(
    .PAIRS_PER_FRAME (PAIRS_PER_FRAME),
    .ADC_BITS        (ADC_BITS)
) u_ifa_checker (.*);
